@@ design/epe_pkg.sv @@
// epe_pkg: shared widths, codes, sequencer types and the power-of-ten table
// for the encoded polyline encoder; no dependencies
package epe_pkg;

   localparam int COORD_W       = 41;
   localparam int MAG_LO_W      = 20;
   localparam int MAG_HI_W      = COORD_W - MAG_LO_W;
   localparam int POW_W         = 24;
   localparam int PROD_W        = MAG_HI_W + POW_W;
   localparam int ACC_W         = 64;
   localparam int SCALE_W       = 32;
   localparam int DELTA_W       = SCALE_W + 1;
   localparam int ZZ_W          = DELTA_W + 1;
   localparam int CHUNK_W       = 5;
   localparam int SYM_W         = 7;
   localparam int PREC_W        = 3;
   localparam int REQ_DATA_W    = 88;
   localparam int RSP_DATA_W    = 8;
   localparam int FRAC_BITS_DEF = 32;

   localparam logic [PREC_W-1:0] PREC_RESET = 3'd5;
   localparam logic [SYM_W-1:0]  SYM_BASE   = 7'd63;
   localparam logic [SYM_W-1:0]  SYM_MAX    = 7'd126;
   // a final chunk never carries the continuation bit
   localparam logic [SYM_W-1:0]  SYM_FINAL_LIMIT = 7'd95;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_SCALE,
      ST_DELTA,
      ST_EMIT
   } epe_state_type;

   typedef struct packed {
      logic req_ready;
      logic mul_hi;
      logic acc_init;
      logic acc_add;
      logic scale_en;
      logic delta_en;
      logic emit_en;
      logic sel_lon;
   } epe_ctrl_type;

   function automatic logic [POW_W-1:0] pow10(input logic [PREC_W-1:0] prec);
      logic [POW_W-1:0] val;
      case (prec)
         3'd0:    val = 24'd1;
         3'd1:    val = 24'd10;
         3'd2:    val = 24'd100;
         3'd3:    val = 24'd1000;
         3'd4:    val = 24'd10000;
         3'd5:    val = 24'd100000;
         3'd6:    val = 24'd1000000;
         3'd7:    val = 24'd10000000;
         default: val = 24'd1;
      endcase
      return val;
   endfunction

endpackage

@@ design/epe_mul.sv @@
// epe_mul: shared unsigned multiplier, half a magnitude times a power of ten,
// product registered; uses epe_pkg
module epe_mul (
   input  logic                           clock,
   input  logic [epe_pkg::MAG_HI_W-1:0]   mul_a,
   input  logic [epe_pkg::POW_W-1:0]      mul_b,
   output logic [epe_pkg::PROD_W-1:0]     prod_ff
);
   import epe_pkg::*;

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ design/epe_ctrl.sv @@
// epe_ctrl: sequencer that walks each coordinate through multiply, round,
// delta and character emission; uses epe_pkg
module epe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  slot_free,
   input  logic                  z_more,
   output epe_pkg::epe_ctrl_type ctrl
);
   import epe_pkg::*;

   epe_state_type state_ff, state_in;
   logic          sel_lon_ff, sel_lon_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sel_lon_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sel_lon_ff <= sel_lon_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      sel_lon_in = sel_lon_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in   = ST_MUL_LO;
               sel_lon_in = 1'b0;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_ACC;
         ST_ACC:    state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DELTA;
         ST_DELTA:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free && !z_more) begin
               if (sel_lon_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in   = ST_MUL_LO;
                  sel_lon_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      ctrl.sel_lon = sel_lon_ff;
      case (state_ff)
         ST_IDLE:   ctrl.req_ready = 1'b1;
         ST_MUL_LO: ctrl.mul_hi    = 1'b0;
         ST_MUL_HI: begin
            ctrl.mul_hi   = 1'b1;
            ctrl.acc_init = 1'b1;
         end
         ST_ACC:    ctrl.acc_add   = 1'b1;
         ST_SCALE:  ctrl.scale_en  = 1'b1;
         ST_DELTA:  ctrl.delta_en  = 1'b1;
         ST_EMIT:   ctrl.emit_en   = slot_free;
         default:   ctrl = '0;
      endcase
   end

endmodule

@@ design/encoded_polyline_encoder.sv @@
// encoded_polyline_encoder: top level with the point datapath and output register
// depends on epe_pkg, epe_mul and epe_ctrl
//
// Usage: one point per req word, latitude in req_tdata[40:0] and longitude in
// req_tdata[81:41], both signed fixed point with FRAC_BITS fraction bits, and
// req_tuser set on the first point of a line. Each point comes out as 2 to 14
// rsp words, one polyline character each (latitude then longitude), with
// rsp_tlast on the final character of the longitude.
// Per coordinate the shared 21x24 multiplier is used twice, low half then high
// half, then the sequencer steps through accumulate, round/saturate and
// delta/zigzag and emits one character per cycle while the output slot is free;
// the next point is accepted only once the longitude's final character is emitted.
// req_tready is high only between points.
// The output register lets the next point be taken while the last character
// still waits; a stalled receiver holds the emit sequence where it is.
// Reset returns to idle, sets precision to 5 and clears the previous point.
// csr_wr_data sets the precision (decimal digits); write only while idle.
module encoded_polyline_encoder #(
   parameter int FRAC_BITS = epe_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [40:0] latitude, [81:41] longitude, [87:82] zero
   input  logic [epe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] first_of_line
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [6:0] symbol, [7] zero
   output logic [epe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_wr_en,
   input  logic [epe_pkg::PREC_W-1:0]       csr_wr_data
);
   import epe_pkg::*;

   localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] POS_MAX  = ACC_W'(64'd2147483647);
   localparam logic [ACC_W-1:0] NEG_MAX  = ACC_W'(64'd2147483648);

   epe_ctrl_type ctrl;

   logic [PREC_W-1:0]  prec_ff;
   logic [COORD_W-1:0] lat_mag_ff, lon_mag_ff;
   logic               lat_neg_ff, lon_neg_ff;
   logic               first_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SCALE_W-1:0] scaled_ff, scaled_in;
   logic [SCALE_W-1:0] prev_lat_ff, prev_lon_ff;
   logic [ZZ_W-1:0]    z_ff, z_in;
   logic               rsp_valid_ff;
   logic [SYM_W-1:0]   rsp_sym_ff, rsp_sym_in;
   logic               rsp_last_ff, rsp_last_in;

   logic                req_fire, slot_free, z_more;
   logic [COORD_W-1:0]  cur_mag;
   logic                cur_neg;
   logic [MAG_HI_W-1:0] mul_a;
   logic [PROD_W-1:0]   prod;
   logic [ACC_W-1:0]    rnd;
   logic [SCALE_W-1:0]  mag32;
   logic [SCALE_W-1:0]  prev_cur;
   logic [DELTA_W-1:0]  delta;
   logic [ZZ_W-1:0]     dbl;

   assign req_fire  = req_tvalid & ctrl.req_ready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign z_more    = |z_ff[ZZ_W-1:CHUNK_W];

   epe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .slot_free (slot_free),
      .z_more    (z_more),
      .ctrl      (ctrl)
   );

   assign cur_mag = ctrl.sel_lon ? lon_mag_ff : lat_mag_ff;
   assign cur_neg = ctrl.sel_lon ? lon_neg_ff : lat_neg_ff;
   assign mul_a   = ctrl.mul_hi ? cur_mag[COORD_W-1:MAG_LO_W]
                                : MAG_HI_W'(cur_mag[MAG_LO_W-1:0]);

   epe_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (pow10(prec_ff)),
      .prod_ff (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= PREC_RESET;
      end else if (csr_wr_en) begin
         prec_ff <= csr_wr_data;
      end
   end

   // latch magnitudes and signs of both coordinates
   always_ff @(posedge clock) begin
      if (req_fire) begin
         lat_neg_ff <= req_tdata[COORD_W-1];
         lat_mag_ff <= req_tdata[COORD_W-1] ? COORD_W'(-req_tdata[COORD_W-1:0])
                                            : req_tdata[COORD_W-1:0];
         lon_neg_ff <= req_tdata[2*COORD_W-1];
         lon_mag_ff <= req_tdata[2*COORD_W-1]
                       ? COORD_W'(-req_tdata[2*COORD_W-1:COORD_W])
                       : req_tdata[2*COORD_W-1:COORD_W];
         first_ff   <= req_tuser;
      end
   end

   // product low half plus rounding bias, then high half shifted in
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_init) begin
         acc_in = ACC_W'(prod) + RND_BIAS;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + (ACC_W'(prod) << MAG_LO_W);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round off fraction bits and saturate to 32-bit signed
   always_comb begin
      rnd = acc_ff >> FRAC_BITS;
      if (cur_neg) begin
         mag32     = (rnd > NEG_MAX) ? NEG_MAX[SCALE_W-1:0] : rnd[SCALE_W-1:0];
         scaled_in = SCALE_W'(-mag32);
      end else begin
         mag32     = (rnd > POS_MAX) ? POS_MAX[SCALE_W-1:0] : rnd[SCALE_W-1:0];
         scaled_in = mag32;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scale_en) begin
         scaled_ff <= scaled_in;
      end
   end

   // delta against the previous point and zigzag
   always_comb begin
      prev_cur = ctrl.sel_lon ? prev_lon_ff : prev_lat_ff;
      if (first_ff) begin
         delta = {scaled_ff[SCALE_W-1], scaled_ff};
      end else begin
         delta = {scaled_ff[SCALE_W-1], scaled_ff} - {prev_cur[SCALE_W-1], prev_cur};
      end
      dbl = {delta, 1'b0};
      z_in = z_ff;
      if (ctrl.delta_en) begin
         z_in = delta[DELTA_W-1] ? ~dbl : dbl;
      end else if (ctrl.emit_en) begin
         z_in = z_ff >> CHUNK_W;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lat_ff <= '0;
         prev_lon_ff <= '0;
      end else if (ctrl.delta_en) begin
         if (ctrl.sel_lon) begin
            prev_lon_ff <= scaled_ff;
         end else begin
            prev_lat_ff <= scaled_ff;
         end
      end
   end

   // one character per word, continuation bit set while more chunks follow
   assign rsp_sym_in  = SYM_W'({z_more, z_ff[CHUNK_W-1:0]}) + SYM_BASE;
   assign rsp_last_in = ctrl.sel_lon & !z_more;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_en) begin
         rsp_sym_ff  <= rsp_sym_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign req_tready = ctrl.req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_sym_ff);
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("req_tready high right after accepting a point");

   a_zigzag_top_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.delta_en |=> !z_ff[ZZ_W-1])
      else $error("zigzag value exceeds 33 bits");

   a_symbol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sym_ff >= SYM_BASE) && (rsp_sym_ff <= SYM_MAX))
      else $error("symbol outside printable range");

   a_final_no_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_sym_ff < SYM_FINAL_LIMIT))
      else $error("final character carries continuation bit");
`endif

endmodule

@@ verif/polyline_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// polyline_scoreboard_pkg: predicts the encoded polyline characters of each point
// and checks the rsp words against them in order; depends on epe_pkg
package polyline_scoreboard_pkg;
   import epe_pkg::*;

   localparam logic [SYM_W-1:0] CONT_FLAG = 7'h20;

   class polyline_scoreboard_type;
      typedef struct packed {
         logic [SYM_W-1:0] symbol;
         logic             last_of_point;
      } polyline_char_type;

      polyline_char_type expected_chars[$];
      int unsigned       frac_bits;
      int unsigned       precision;
      longint            prev_lat;
      longint            prev_lon;
      int unsigned       mismatches;
      int unsigned       points_noted;
      int unsigned       chars_checked;
      int unsigned       saturated;

      function new(int unsigned frac);
         frac_bits     = frac;
         precision     = int'(PREC_RESET);
         prev_lat      = 0;
         prev_lon      = 0;
         mismatches    = 0;
         points_noted  = 0;
         chars_checked = 0;
         saturated     = 0;
      endfunction

      function void set_precision(logic [PREC_W-1:0] digits);
         precision = int'(digits);
      endfunction

      function int unsigned pending();
         return expected_chars.size();
      endfunction

      // times 10^precision, round half away from zero, clamp to 32-bit signed
      function longint scale_round(logic [COORD_W-1:0] raw);
         logic [COORD_W-1:0] mag;
         logic [63:0]        factor;
         logic [63:0]        rounded;
         factor = 64'd1;
         repeat (precision) factor = factor * 64'd10;
         mag = raw[COORD_W-1] ? ~raw + COORD_W'(1) : raw;
         rounded = (64'(mag) * factor + (64'd1 << (frac_bits - 1))) >> frac_bits;
         if (raw[COORD_W-1]) begin
            if (rounded > 64'd2147483648) begin
               rounded = 64'd2147483648;
               saturated++;
            end
            return -longint'(rounded);
         end
         if (rounded > 64'd2147483647) begin
            rounded = 64'd2147483647;
            saturated++;
         end
         return longint'(rounded);
      endfunction

      // zigzag the difference at 34 bits, then 5-bit chunks lsb first
      function void push_chars(longint delta, logic tail);
         logic [63:0]      zz;
         logic [SYM_W-1:0] sym;
         zz = 64'(delta) << 1;
         if (delta < 0) zz = ~zz;
         zz = zz & ((64'd1 << ZZ_W) - 64'd1);
         while (zz >= 64'h20) begin
            sym = (CONT_FLAG | {2'b00, zz[CHUNK_W-1:0]}) + SYM_BASE;
            expected_chars.push_back('{sym, 1'b0});
            zz = zz >> CHUNK_W;
         end
         sym = {2'b00, zz[CHUNK_W-1:0]} + SYM_BASE;
         expected_chars.push_back('{sym, tail});
      endfunction

      function void note_point(logic [COORD_W-1:0] lat, logic [COORD_W-1:0] lon,
                               logic first);
         longint lat_scaled;
         longint lon_scaled;
         lat_scaled = scale_round(lat);
         lon_scaled = scale_round(lon);
         push_chars(first ? lat_scaled : lat_scaled - prev_lat, 1'b0);
         push_chars(first ? lon_scaled : lon_scaled - prev_lon, 1'b1);
         prev_lat = lat_scaled;
         prev_lon = lon_scaled;
         points_noted++;
      endfunction

      function void flag(string what, logic [RSP_DATA_W-1:0] exp_data, logic exp_last,
                         logic [RSP_DATA_W-1:0] got_data, logic got_last);
         if (mismatches < 10)
            $display("mismatch at %0t: %s, expected symbol %h last %b, got %h last %b",
                     $time, what, exp_data, exp_last, got_data, got_last);
         mismatches++;
      endfunction

      function void check_char(logic [RSP_DATA_W-1:0] data, logic last);
         polyline_char_type want;
         chars_checked++;
         if (expected_chars.size() == 0) begin
            flag("word with nothing expected", 'x, 1'bx, data, last);
            return;
         end
         want = expected_chars.pop_front();
         if (data !== {1'b0, want.symbol} || last !== want.last_of_point)
            flag("wrong character", {1'b0, want.symbol}, want.last_of_point, data, last);
      endfunction
   endclass

endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives points into encoded_polyline_encoder under random stalls and
// precision changes; depends on epe_pkg, polyline_scoreboard_pkg and the design
module testbench;
   import epe_pkg::*;
   import polyline_scoreboard_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int QUIET_LIMIT   = 4000;

   localparam logic [COORD_W-1:0] COORD_MAX = 41'h0FF_FFFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 41'h100_0000_0000;
   localparam logic [COORD_W-1:0] HALF_UNIT = 41'h000_8000_0000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_wr_en;
   logic [PREC_W-1:0]       csr_wr_data;

   logic                    hold_rsp;
   logic                    gaps_on;
   logic [7:0]              precisions_seen;
   int unsigned             quiet_cycles;
   polyline_scoreboard_type sb;

   encoded_polyline_encoder #(.FRAC_BITS(FRAC_BITS_DEF)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_char(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("no word moved for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: steady stretches, short random stalls, now and then a long one
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned mode_left;
      int unsigned mode;
      int unsigned pick;
      logic        hold_seen;
      stall_left = 0;
      mode_left  = 0;
      mode       = 0;
      hold_seen  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_seen) begin
            hold_seen  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 400);
         end else begin
            mode_left--;
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (mode == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (pick < 97) ? $urandom_range(0, 3) : $urandom_range(15, 60);
            end
         end
      end
   end

   // valid stays up after acceptance; the caller lowers it for a gap
   task automatic send_point(logic [COORD_W-1:0] lat, logic [COORD_W-1:0] lon,
                             logic first);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 2 * COORD_W){1'b0}}, lon, lat};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      sb.note_point(lat, lon, first);
   endtask

   task automatic pace_sender();
      int unsigned pick;
      int unsigned gap;
      if (!gaps_on) return;
      pick = $urandom_range(0, 99);
      gap  = (pick < 65) ? 0 : (pick < 96) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_precision(logic [PREC_W-1:0] digits);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= digits;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_precision(digits);
      precisions_seen[digits] = 1'b1;
   endtask

   function automatic logic [COORD_W-1:0] fresh_coord();
      logic [63:0] bits;
      int unsigned pick;
      bits = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // plausible map coordinates, magnitudes spread over many octaves
         bits[63:40] = '0;
         bits = bits >> $urandom_range(0, 16);
         return ($urandom_range(0, 1) != 0) ? -bits[COORD_W-1:0] : bits[COORD_W-1:0];
      end
      if (pick < 75) return bits[COORD_W-1:0];
      case ($urandom_range(0, 6))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return '1;
         4:       return HALF_UNIT;
         5:       return -HALF_UNIT;
         default: return HALF_UNIT * 3;
      endcase
   endfunction

   // mostly a small walk from the previous point, so deltas stay short
   function automatic logic [COORD_W-1:0] next_coord(logic [COORD_W-1:0] prev);
      logic signed [63:0] step;
      if ($urandom_range(0, 99) >= 80) return fresh_coord();
      step = $signed($urandom);
      step = step >>> $urandom_range(0, 31);
      step = step <<< $urandom_range(0, 8);
      return prev + step[COORD_W-1:0];
   endfunction

   task automatic run_random_lines(int unsigned count);
      int unsigned        sent;
      int unsigned        len;
      int unsigned        i;
      logic [COORD_W-1:0] lat;
      logic [COORD_W-1:0] lon;
      logic               first;
      sent = 0;
      while (sent < count) begin
         len   = $urandom_range(1, 16);
         lat   = fresh_coord();
         lon   = fresh_coord();
         first = ($urandom_range(0, 9) != 0);
         for (i = 0; i < len && sent < count; i++) begin
            if (i != 0) begin
               lat   = next_coord(lat);
               lon   = next_coord(lon);
               first = ($urandom_range(0, 19) == 0);
            end
            send_point(lat, lon, first);
            sent++;
            pace_sender();
         end
         if ($urandom_range(0, 29) == 0) wait_drained();
      end
   endtask

   task automatic run_directed();
      // precision 5 out of reset, no line started yet
      send_point('0, '0, 1'b0);
      send_point(41'sd4294967296, -41'sd4294967296, 1'b0);
      send_point(41'sd165356240896, -41'sd516255068979, 1'b1);
      send_point(41'sd174805168947, -41'sd519476294451, 1'b0);
      send_point(41'sd185765925487, -41'sd543111499481, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      // largest scale: saturation and the widest zigzag values
      write_precision(3'd7);
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point('1, 41'd1, 1'b0);
      // integer scale: ties round away from zero
      write_precision(3'd0);
      send_point(HALF_UNIT, -HALF_UNIT, 1'b1);
      send_point(HALF_UNIT - 1, -(HALF_UNIT - 1), 1'b0);
      send_point(HALF_UNIT * 3, -(HALF_UNIT * 3), 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point('0, '0, 1'b0);
      send_point(41'sd68719476736, -41'sd68719476736, 1'b1);
   endtask

   initial begin : stimulus
      int unsigned phase;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      hold_rsp        = 1'b0;
      gaps_on         = 1'b1;
      precisions_seen = 8'h20;
      sb              = new(FRAC_BITS_DEF);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (phase = 0; phase < 8; phase++) begin
         write_precision(phase == 0 ? 3'd7 : phase == 1 ? 3'd0 : 3'($urandom_range(0, 7)));
         gaps_on = (phase % 3 != 1);
         // receiver holds off while points keep coming, so the input backs up
         if (phase == 2) hold_rsp <= 1'b1;
         run_random_lines(52);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d points and %0d characters, %0d saturated coordinates",
               sb.points_noted, sb.chars_checked, sb.saturated);
      $display("precisions used (bit per value) %b, %0d mismatches",
               precisions_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/epe_pkg.sv
design/epe_mul.sv
design/epe_ctrl.sv
design/encoded_polyline_encoder.sv
verif/polyline_scoreboard_pkg.sv
verif/testbench.sv
